// ===== src/lr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer: opcodes, queue depth
// and the control groups passed between the setup, queue and stepping parts.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    localparam int COLOUR_BITS = 24;
    localparam int QUEUE_DEPTH = 4;

    // classification of one queued command
    typedef struct packed {
        logic is_start;
        logic mirror;
        logic swap;
    } t_cmd_flags;

    // stepping part status seen by the top level
    typedef struct packed {
        logic active;
        logic emit;
        logic last;
    } t_back_status;

endpackage
`default_nettype wire

// ===== src/line_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Midpoint line rasterizer for all octants.
//
// Requests enter on the s_axis channel: tuser = 0 starts a line from the
// endpoints and colour in tdata, tuser = 1 asks for the next pixel. Each
// start gives its first pixel; each next request gives one more pixel while
// a line is active and nothing otherwise. Pixels leave on m_axis with tlast
// set on the final pixel of a line. A start during an active line drops the
// old line.
// On its way to a pixel, a request is written into the command queue by
// the setup logic, and the stepping stage then loads the output register.
// Throughput is one request per cycle while the receiver does not stall,
// with the stepping stage updating the decision variable for each request.
// Reset clears the queue, the output valid and the active line. When the
// receiver stalls the output register holds its pixel, the queue fills and
// s_axis tready drops once all queue entries are taken.
// ----------------------------------------------------------------------------
module line_rasterizer_core #(
    parameter int COORD_BITS = 12,
    localparam int IN_W  = ((4 * COORD_BITS + lr_pkg::COLOUR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + lr_pkg::COLOUR_BITS + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // x_start, y_start, x_end, y_end, colour
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    // opcode
    input  wire logic              i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // pixel_x, pixel_y, pixel_colour
    output logic [OUT_W-1:0]       o_m_axis_tdata,
    // last_pixel
    output logic                   o_m_axis_tlast
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 4;
    localparam int PW = COORD_BITS + 1;
    localparam int FW = $bits(lr_pkg::t_cmd_flags);
    localparam int EW = FW + 3 * DW + 3 * PW + CB + lr_pkg::COLOUR_BITS;
    localparam int QCW = $clog2(lr_pkg::QUEUE_DEPTH + 1);

    lr_pkg::t_cmd_flags             f_flags, q_flags;
    logic signed [DW-1:0]           f_dec, f_ss, f_sd, q_dec, q_ss, q_sd;
    logic [PW-1:0]                  f_major, f_minor, f_limit;
    logic [PW-1:0]                  q_major, q_minor, q_limit;
    logic [CB-1:0]                  f_mrow, q_mrow;
    logic [lr_pkg::COLOUR_BITS-1:0] f_colour, q_colour;
    logic                           f_push, q_full, q_valid, q_pop;
    logic [EW-1:0]                  q_wdata, q_rdata;
    logic [QCW-1:0]                 q_count;
    logic [CB-1:0]                  px, py;
    logic [lr_pkg::COLOUR_BITS-1:0] pcol;
    lr_pkg::t_back_status           b_status;

    lr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_valid         (i_s_axis_tvalid),
        .i_opcode        (i_s_axis_tuser),
        .i_x_start       (i_s_axis_tdata[CB-1:0]),
        .i_y_start       (i_s_axis_tdata[2*CB-1:CB]),
        .i_x_end         (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_y_end         (i_s_axis_tdata[4*CB-1:3*CB]),
        .i_colour        (i_s_axis_tdata[4*CB+lr_pkg::COLOUR_BITS-1:4*CB]),
        .i_queue_full    (q_full),
        .o_ready         (o_s_axis_tready),
        .o_push          (f_push),
        .o_flags         (f_flags),
        .o_decision      (f_dec),
        .o_step_straight (f_ss),
        .o_step_diagonal (f_sd),
        .o_major         (f_major),
        .o_minor         (f_minor),
        .o_limit         (f_limit),
        .o_mirror_row    (f_mrow),
        .o_colour        (f_colour)
    );

    assign q_wdata = {f_flags, f_dec, f_ss, f_sd, f_major, f_minor, f_limit, f_mrow, f_colour};

    lr_cmd_queue #(.WIDTH(EW), .DEPTH(lr_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count)
    );

    assign {q_flags, q_dec, q_ss, q_sd, q_major, q_minor, q_limit, q_mrow, q_colour} = q_rdata;

    lr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_flags         (q_flags),
        .i_decision      (q_dec),
        .i_step_straight (q_ss),
        .i_step_diagonal (q_sd),
        .i_major         (q_major),
        .i_minor         (q_minor),
        .i_limit         (q_limit),
        .i_mirror_row    (q_mrow),
        .i_colour        (q_colour),
        .i_m_tready      (i_m_axis_tready),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_pixel_x       (px),
        .o_pixel_y       (py),
        .o_pixel_colour  (pcol),
        .o_last_pixel    (o_m_axis_tlast),
        .o_status        (b_status)
    );

    assign o_m_axis_tdata = OUT_W'({pcol, py, px});

    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCW'(lr_pkg::QUEUE_DEPTH))
        else $error("command queue overflow");

    // a start command always yields a pixel
    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_flags.is_start) |=> o_m_axis_tvalid)
        else $error("start command produced no pixel");

    // the final pixel ends the line
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_status.emit && b_status.last) |=> !b_status.active)
        else $error("line still active after final pixel");

endmodule
`default_nettype wire

// ===== src/lr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_front
// Request intake: classifies start and next requests and, for a start,
// orders the endpoints, mirrors falling lines, swaps steep axes and forms
// the decision variable and its increments for the command queue.
// ----------------------------------------------------------------------------
module lr_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              i_valid,
    input  wire logic                              i_opcode,
    input  wire logic [COORD_BITS-1:0]             i_x_start,
    input  wire logic [COORD_BITS-1:0]             i_y_start,
    input  wire logic [COORD_BITS-1:0]             i_x_end,
    input  wire logic [COORD_BITS-1:0]             i_y_end,
    input  wire logic [lr_pkg::COLOUR_BITS-1:0]    i_colour,
    input  wire logic                              i_queue_full,
    output logic                                   o_ready,
    output logic                                   o_push,
    output lr_pkg::t_cmd_flags                     o_flags,
    output logic signed [COORD_BITS+3:0]           o_decision,
    output logic signed [COORD_BITS+3:0]           o_step_straight,
    output logic signed [COORD_BITS+3:0]           o_step_diagonal,
    output logic [COORD_BITS:0]                    o_major,
    output logic [COORD_BITS:0]                    o_minor,
    output logic [COORD_BITS:0]                    o_limit,
    output logic [COORD_BITS-1:0]                  o_mirror_row,
    output logic [lr_pkg::COLOUR_BITS-1:0]         o_colour
);

    localparam int DW = COORD_BITS + 4;
    localparam int PW = COORD_BITS + 1;

    logic                  a_first;
    logic [COORD_BITS-1:0] xl, yl, xr, yr;
    logic signed [DW-1:0]  dx, dy, dy_abs;
    logic                  mirror, swap;
    logic [PW-1:0]         yr_m;

    assign o_ready = ~i_queue_full;
    assign o_push  = i_valid & ~i_queue_full;

    always_comb begin
        a_first = (i_x_start < i_x_end) ||
                  ((i_x_start == i_x_end) && (i_y_start < i_y_end));
        if (a_first) begin
            xl = i_x_start; yl = i_y_start; xr = i_x_end; yr = i_y_end;
        end else begin
            xl = i_x_end; yl = i_y_end; xr = i_x_start; yr = i_y_start;
        end
        dx = $signed({4'b0, xr}) - $signed({4'b0, xl});
        dy = $signed({4'b0, yr}) - $signed({4'b0, yl});

        mirror = (dx != '0) && dy[DW-1];
        dy_abs = mirror ? -dy : dy;
        yr_m   = mirror ? ({yl, 1'b0} - {1'b0, yr}) : {1'b0, yr};
        swap   = dy_abs > dx;

        o_flags.is_start = (i_opcode == lr_pkg::OP_START);
        o_flags.mirror   = mirror;
        o_flags.swap     = swap;

        if (swap) begin
            o_decision      = {dx[DW-2:0], 1'b0} - dy_abs;
            o_step_straight = {dx[DW-2:0], 1'b0};
            o_step_diagonal = {dx[DW-2:0], 1'b0} - {dy_abs[DW-2:0], 1'b0};
            o_major         = {1'b0, yl};
            o_minor         = {1'b0, xl};
            o_limit         = yr_m;
        end else begin
            o_decision      = {dy_abs[DW-2:0], 1'b0} - dx;
            o_step_straight = {dy_abs[DW-2:0], 1'b0};
            o_step_diagonal = {dy_abs[DW-2:0], 1'b0} - {dx[DW-2:0], 1'b0};
            o_major         = {1'b0, xl};
            o_minor         = {1'b0, yl};
            o_limit         = {1'b0, xr};
        end
        o_mirror_row = yl;
        o_colour     = i_colour;
    end

endmodule
`default_nettype wire

// ===== src/lr_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_cmd_queue
// Small register queue between the intake and the stepping part, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module lr_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_valid,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_pop;

    assign do_pop  = i_pop & (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/lr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_back
// Stepping part: holds the line state, advances one pixel per command,
// undoes the mirror and axis swap and drives the registered pixel output.
// ----------------------------------------------------------------------------
module lr_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    output logic                                   o_q_pop,
    input  wire lr_pkg::t_cmd_flags                i_flags,
    input  wire logic signed [COORD_BITS+3:0]      i_decision,
    input  wire logic signed [COORD_BITS+3:0]      i_step_straight,
    input  wire logic signed [COORD_BITS+3:0]      i_step_diagonal,
    input  wire logic [COORD_BITS:0]               i_major,
    input  wire logic [COORD_BITS:0]               i_minor,
    input  wire logic [COORD_BITS:0]               i_limit,
    input  wire logic [COORD_BITS-1:0]             i_mirror_row,
    input  wire logic [lr_pkg::COLOUR_BITS-1:0]    i_colour,
    input  wire logic                              i_m_tready,
    output logic                                   o_m_tvalid,
    output logic [COORD_BITS-1:0]                  o_pixel_x,
    output logic [COORD_BITS-1:0]                  o_pixel_y,
    output logic [lr_pkg::COLOUR_BITS-1:0]         o_pixel_colour,
    output logic                                   o_last_pixel,
    output lr_pkg::t_back_status                   o_status
);

    localparam int DW = COORD_BITS + 4;
    localparam int PW = COORD_BITS + 1;

    logic signed [DW-1:0]             r_dec, n_dec;
    logic signed [DW-1:0]             r_ss, n_ss;
    logic signed [DW-1:0]             r_sd, n_sd;
    logic [PW-1:0]                    r_major, n_major;
    logic [PW-1:0]                    r_minor, n_minor;
    logic [PW-1:0]                    r_limit, n_limit;
    logic [COORD_BITS-1:0]            r_mrow, n_mrow;
    logic                             r_mirror, n_mirror;
    logic                             r_swap, n_swap;
    logic                             r_active, n_active;
    logic [lr_pkg::COLOUR_BITS-1:0]   r_colour, n_colour;

    logic                             r_out_valid;
    logic [COORD_BITS-1:0]            r_out_x, r_out_y;
    logic [lr_pkg::COLOUR_BITS-1:0]   r_out_colour;
    logic                             r_out_last;

    logic                             can_take, pop, emit, last;
    logic [PW-1:0]                    col, row, row_m;

    assign can_take = ~r_out_valid | i_m_tready;
    assign pop      = i_q_valid & can_take;
    assign o_q_pop  = pop;

    always_comb begin
        n_dec    = r_dec;
        n_ss     = r_ss;
        n_sd     = r_sd;
        n_major  = r_major;
        n_minor  = r_minor;
        n_limit  = r_limit;
        n_mrow   = r_mrow;
        n_mirror = r_mirror;
        n_swap   = r_swap;
        n_active = r_active;
        n_colour = r_colour;
        emit     = 1'b0;

        if (pop) begin
            if (i_flags.is_start) begin
                n_dec    = i_decision;
                n_ss     = i_step_straight;
                n_sd     = i_step_diagonal;
                n_major  = i_major;
                n_minor  = i_minor;
                n_limit  = i_limit;
                n_mrow   = i_mirror_row;
                n_mirror = i_flags.mirror;
                n_swap   = i_flags.swap;
                n_colour = i_colour;
                n_active = 1'b1;
                emit     = 1'b1;
            end else if (r_active) begin
                if (r_dec <= 0) begin
                    n_dec = r_dec + r_ss;
                end else begin
                    n_dec   = r_dec + r_sd;
                    n_minor = r_minor + 1'b1;
                end
                n_major = r_major + 1'b1;
                emit    = 1'b1;
            end
        end

        // undo axis swap and mirror
        col   = n_swap ? n_minor : n_major;
        row   = n_swap ? n_major : n_minor;
        row_m = n_mirror ? ({n_mrow, 1'b0} - row) : row;
        last  = (n_major >= n_limit);
        if (emit && last) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            if (pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec    <= n_dec;
        r_ss     <= n_ss;
        r_sd     <= n_sd;
        r_major  <= n_major;
        r_minor  <= n_minor;
        r_limit  <= n_limit;
        r_mrow   <= n_mrow;
        r_mirror <= n_mirror;
        r_swap   <= n_swap;
        r_colour <= n_colour;
        if (pop && emit) begin
            r_out_x      <= col[COORD_BITS-1:0];
            r_out_y      <= row_m[COORD_BITS-1:0];
            r_out_colour <= n_colour;
            r_out_last   <= last;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_pixel_x       = r_out_x;
    assign o_pixel_y       = r_out_y;
    assign o_pixel_colour  = r_out_colour;
    assign o_last_pixel    = r_out_last;
    assign o_status.active = r_active;
    assign o_status.emit   = pop & emit;
    assign o_status.last   = last;

endmodule
`default_nettype wire
